// ===== design/timer_event_queue_macros.svh =====
// assertion macros used by the timer event queue checker
`ifndef TIMER_EVENT_QUEUE_MACROS_SVH
`define TIMER_EVENT_QUEUE_MACROS_SVH

// checked property, skipped while reset is high
`define TEQ_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds across reset
`define TEQ_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/teq_pkg.sv =====
// shared types and constants of the timer event queue
package teq_pkg;

  localparam int SLOT_BITS_DEF    = 4;
  localparam int COUNTER_BITS_DEF = 12;
  localparam int QUEUE_BITS       = 2;

  localparam logic [1:0] CMD_POST    = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [2:0] KIND_POSTED      = 3'd0;
  localparam logic [2:0] KIND_REJECTED    = 3'd1;
  localparam logic [2:0] KIND_CANCELLED   = 3'd2;
  localparam logic [2:0] KIND_CANCEL_FAIL = 3'd3;
  localparam logic [2:0] KIND_EXPIRED     = 3'd4;
  localparam logic [2:0] KIND_REPORT      = 3'd5;

  typedef enum logic [1:0] {
    OP_POST,
    OP_CANCEL,
    OP_ADVANCE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_PICK,
    ST_FIRE,
    ST_NEXT_DUE,
    ST_REPORT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [3:0]  slot;
    logic [30:0] delay;
    logic [31:0] period;
    logic [15:0] tag;
    logic [15:0] event_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic [3:0]  out_slot;
    logic [15:0] out_tag;
    logic [31:0] wait_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// ===== design/teq_front.sv =====
// front end: accepts commands, classifies them and queues them for the back end
module teq_front import teq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  in_item_t cmd_item,
  output q_head_t  head,
  input  logic     pop
);

  localparam int QDEPTH = 1 << QUEUE_BITS;

  q_entry_t              q_mem [QDEPTH];
  logic [QUEUE_BITS-1:0] wr_ptr;
  logic [QUEUE_BITS-1:0] rd_ptr;
  logic [QUEUE_BITS:0]   count;
  logic                  push;
  logic                  known;
  op_t                   op;

  always_comb begin
    known = 1'b1;
    op    = OP_POST;
    case (cmd_item.cmd)
      CMD_POST:    op = OP_POST;
      CMD_CANCEL:  op = OP_CANCEL;
      CMD_ADVANCE: op = OP_ADVANCE;
      default:     known = 1'b0;
    endcase
  end

  assign cmd_stall = (count == (QUEUE_BITS+1)'(QDEPTH));
  // unknown commands are taken and dropped
  assign push      = cmd_valid && !cmd_stall && known;

  assign head.valid = (count != '0);
  assign head.entry = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{op: op, item: cmd_item};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_BITS+1)'(push) - (QUEUE_BITS+1)'(pop);
    end
  end

endmodule

// ===== design/teq_back.sv =====
// back end: slot table, dispatch sequencer and result register
module teq_back import teq_pkg::*; #(
  parameter int SLOT_BITS    = SLOT_BITS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  localparam int NS = 1 << SLOT_BITS;

  logic [31:0]             due_time  [NS];
  logic [31:0]             rep_int   [NS];
  logic [15:0]             h_tag     [NS];
  logic [15:0]             arm_ord   [NS];
  logic [COUNTER_BITS-1:0] slot_cnt  [NS];
  logic [NS-1:0]           armed;
  logic [15:0]             order_ctr;

  back_state_t             state, state_next;
  logic [SLOT_BITS-1:0]    idx, idx_next;
  logic [NS-1:0]           mask, mask_next;
  logic                    found, found_next;
  logic [SLOT_BITS-1:0]    best_slot, best_slot_next;
  logic signed [31:0]      best_ds, best_ds_next;
  logic [15:0]             best_order, best_order_next;
  logic [31:0]             best_due, best_due_next;
  logic [31:0]             best_per, best_per_next;
  logic [15:0]             best_tag, best_tag_next;
  logic [COUNTER_BITS-1:0] best_cnt, best_cnt_next;
  logic                    have, have_next;
  logic signed [31:0]      best_wait, best_wait_next;

  logic                    out_free;
  logic                    emit;
  out_item_t               emit_item;
  logic [SLOT_BITS-1:0]    rd_idx;
  logic [SLOT_BITS-1:0]    upd;
  logic                    ent_wr, arm_set, arm_clr, cnt_wr, order_inc;
  logic [31:0]             wr_due;
  logic [31:0]             wr_per;
  logic [15:0]             wr_tag;
  logic [COUNTER_BITS-1:0] cnt_val;

  in_item_t                it;
  logic [31:0]             post_slot32;
  logic [31:0]             eid_slot32;
  logic [31:0]             eid_cnt32;
  logic [31:0]             id32;
  logic [31:0]             rd_idx32;
  logic [31:0]             best_slot32;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic signed [31:0]      cand_ds;
  logic signed [31:0]      cand_wait;
  logic signed [15:0]      ord_diff;
  logic [31:0]             rearm_t;
  logic signed [31:0]      rearm_ds;
  logic                    better;
  logic                    scan_last;

  assign it          = head.entry.item;
  assign post_slot32 = 32'(it.slot);
  assign eid_slot32  = 32'(it.event_id);
  assign eid_cnt32   = 32'(it.event_id) >> SLOT_BITS;
  assign out_free    = !res_valid || !res_stall;
  assign scan_last   = (idx == SLOT_BITS'(NS - 1));

  always_comb begin
    rd_idx = idx;
    if (state == ST_IDLE) begin
      if (head.entry.op == OP_CANCEL) rd_idx = eid_slot32[SLOT_BITS-1:0];
      else rd_idx = post_slot32[SLOT_BITS-1:0];
    end
  end

  assign rd_idx32    = 32'(rd_idx);
  assign best_slot32 = 32'(best_slot);
  assign cand_ds     = $signed(due_time[rd_idx] - it.now);
  assign cand_wait   = cand_ds[31] ? 32'sd0 : cand_ds;
  assign ord_diff    = $signed(arm_ord[rd_idx] - best_order);
  assign better      = !found || (cand_ds < best_ds) ||
                       ((cand_ds == best_ds) && (ord_diff < 16'sd0));
  assign rearm_t     = best_due + best_per;
  assign rearm_ds    = $signed(rearm_t - it.now);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    mask_next       = mask;
    found_next      = found;
    best_slot_next  = best_slot;
    best_ds_next    = best_ds;
    best_order_next = best_order;
    best_due_next   = best_due;
    best_per_next   = best_per;
    best_tag_next   = best_tag;
    best_cnt_next   = best_cnt;
    have_next       = have;
    best_wait_next  = best_wait;
    pop             = 1'b0;
    emit            = 1'b0;
    emit_item       = '0;
    upd             = rd_idx;
    ent_wr          = 1'b0;
    arm_set         = 1'b0;
    arm_clr         = 1'b0;
    cnt_wr          = 1'b0;
    order_inc       = 1'b0;
    wr_due          = it.now + 32'(it.delay);
    wr_per          = it.period;
    wr_tag          = it.tag;
    cnt_val         = slot_cnt[rd_idx];
    id32            = (32'(slot_cnt[rd_idx]) << SLOT_BITS) | rd_idx32;
    cnt_inc         = slot_cnt[rd_idx] + 1'b1;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          case (head.entry.op)
            OP_POST: begin
              if (out_free) begin
                pop                = 1'b1;
                emit               = 1'b1;
                emit_item.result_id = id32[15:0];
                emit_item.out_slot = rd_idx32[3:0];
                emit_item.last     = 1'b1;
                if (armed[rd_idx]) begin
                  emit_item.kind = KIND_REJECTED;
                end else begin
                  emit_item.kind = KIND_POSTED;
                  ent_wr         = 1'b1;
                  arm_set        = 1'b1;
                  order_inc      = 1'b1;
                end
              end
            end
            OP_CANCEL: begin
              if (out_free) begin
                pop                 = 1'b1;
                emit                = 1'b1;
                emit_item.result_id = it.event_id;
                emit_item.out_slot  = rd_idx32[3:0];
                emit_item.last      = 1'b1;
                if (armed[rd_idx] && (32'(slot_cnt[rd_idx]) == eid_cnt32)) begin
                  emit_item.kind = KIND_CANCELLED;
                  arm_clr        = 1'b1;
                  cnt_wr         = 1'b1;
                  cnt_val        = (cnt_inc == '0) ? COUNTER_BITS'(1) : cnt_inc;
                end else begin
                  emit_item.kind = KIND_CANCEL_FAIL;
                end
              end
            end
            OP_ADVANCE: begin
              state_next = ST_MARK;
              idx_next   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        mask_next[idx] = armed[idx] && (cand_ds <= 32'sd0);
        idx_next       = idx + 1'b1;
        if (scan_last) begin
          state_next = ST_PICK;
          found_next = 1'b0;
        end
      end
      ST_PICK: begin
        if (mask[idx] && better) begin
          found_next      = 1'b1;
          best_slot_next  = idx;
          best_ds_next    = cand_ds;
          best_order_next = arm_ord[idx];
          best_due_next   = due_time[idx];
          best_per_next   = rep_int[idx];
          best_tag_next   = h_tag[idx];
          best_cnt_next   = slot_cnt[idx];
        end
        idx_next = idx + 1'b1;
        if (scan_last) begin
          if (found_next) begin
            state_next = ST_FIRE;
          end else begin
            state_next = ST_NEXT_DUE;
            have_next  = 1'b0;
          end
        end
      end
      ST_FIRE: begin
        if (out_free) begin
          id32                 = (32'(best_cnt) << SLOT_BITS) | best_slot32;
          emit                 = 1'b1;
          emit_item.kind       = KIND_EXPIRED;
          emit_item.result_id  = id32[15:0];
          emit_item.out_slot   = best_slot32[3:0];
          emit_item.out_tag    = best_tag;
          upd                  = best_slot;
          mask_next[best_slot] = 1'b0;
          if (!best_per[31]) begin
            ent_wr    = 1'b1;
            order_inc = 1'b1;
            wr_due    = rearm_ds[31] ? it.now : rearm_t;
            wr_per    = best_per;
            wr_tag    = best_tag;
          end else begin
            cnt_inc = best_cnt + 1'b1;
            arm_clr = 1'b1;
            cnt_wr  = 1'b1;
            cnt_val = (cnt_inc == '0) ? COUNTER_BITS'(1) : cnt_inc;
          end
          state_next = ST_PICK;
          idx_next   = '0;
          found_next = 1'b0;
        end
      end
      ST_NEXT_DUE: begin
        if (armed[idx] && (!have || (cand_wait < best_wait))) begin
          have_next      = 1'b1;
          best_wait_next = cand_wait;
        end
        idx_next = idx + 1'b1;
        if (scan_last) state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          pop                = 1'b1;
          emit               = 1'b1;
          emit_item.kind     = KIND_REPORT;
          emit_item.wait_res = have ? best_wait : 32'hFFFF_FFFF;
          emit_item.last     = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      armed     <= '0;
      order_ctr <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NS; i++) slot_cnt[i] <= '1;
    end else begin
      state <= state_next;
      if (arm_set) armed[upd] <= 1'b1;
      if (arm_clr) armed[upd] <= 1'b0;
      if (order_inc) order_ctr <= order_ctr + 1'b1;
      if (cnt_wr) slot_cnt[upd] <= cnt_val;
      if (emit) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_wr) begin
      due_time[upd] <= wr_due;
      rep_int[upd]  <= wr_per;
      h_tag[upd]    <= wr_tag;
      arm_ord[upd]  <= order_ctr;
    end
    if (emit) res_item <= emit_item;
    idx        <= idx_next;
    mask       <= mask_next;
    found      <= found_next;
    best_slot  <= best_slot_next;
    best_ds    <= best_ds_next;
    best_order <= best_order_next;
    best_due   <= best_due_next;
    best_per   <= best_per_next;
    best_tag   <= best_tag_next;
    best_cnt   <= best_cnt_next;
    have       <= have_next;
    best_wait  <= best_wait_next;
  end

endmodule

// ===== design/timer_event_queue.sv =====
// Timer event queue: sixteen event slots, post, cancel and timed dispatch.
// Input channel cmd_valid/cmd_stall/cmd_item carries post, cancel and advance
// commands; a command is taken when cmd_valid is high and cmd_stall low. A
// four-entry command queue sits between the front end and the dispatch
// sequencer, so commands keep being taken while a result waits.
// Result channel res_valid/res_stall/res_item: one result per transfer, the
// final result of a command has last set. While res_stall is high the result
// register holds and the sequencer waits.
// Post and cancel: one result, which passes through the command queue and the result register.
// Advance: one compare unit steps through the slot table one slot a cycle:
// it marks the due slots, then for each expired event scans for the earliest
// and transfers it, then makes a last scan that finds none, a deadline scan
// and the report; the report is registered after all expired events, and
// stalls on the result channel hold the sequence.
// Reset (rst, synchronous) disarms all slots, sets each slot counter to all
// ones, clears the order stamp and empties the command queue.
module timer_event_queue import teq_pkg::*; #(
  parameter int SLOT_BITS    = SLOT_BITS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  in_item_t  cmd_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  q_head_t head;
  logic    pop;

  teq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .head      (head),
    .pop       (pop)
  );

  teq_back #(
    .SLOT_BITS    (SLOT_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== design/teq_checker.sv =====
// port checker for the timer event queue and its bind
`include "timer_event_queue_macros.svh"

module teq_checker import teq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input in_item_t  cmd_item,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  `TEQ_CHECK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_item), "result changed while stalled")
  `TEQ_CHECK(a_cmd_hold, cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_item), "command changed while stalled")
  `TEQ_CHECK_ALWAYS(a_reset_quiet, rst |=> !res_valid, "result shown right after reset")
  `TEQ_CHECK(a_report_last, res_valid && (res_item.kind == KIND_REPORT) |-> res_item.last, "deadline report without last")
  `TEQ_CHECK(a_expired_not_last, res_valid && (res_item.kind == KIND_EXPIRED) |-> !res_item.last && (res_item.wait_res == 32'd0), "expired event marked last or with a wait")

endmodule

bind timer_event_queue teq_checker u_teq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd_item  (cmd_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
